// ----- rtl/tqoe_pkg.sv -----
package tqoe_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = 4;
    localparam int CNT_W       = 5;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
    localparam logic [2:0] KIND_FIRED     = 3'd4;
    localparam logic [2:0] KIND_NONE      = 3'd5;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] due;
        logic [23:0] period;
        logic [31:0] fires;
    } t_entry;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] fires;
    } t_result;

    typedef struct packed {
        logic is_due;
        logic is_earlier;
    } t_cmp_flags;

endpackage

// ----- rtl/tqoe_order_cmp.sv -----
module tqoe_order_cmp
    import tqoe_pkg::*;
(
    input  logic [31:0] i_now,
    input  logic [31:0] i_cand_due,
    input  logic [31:0] i_cand_id,
    input  logic [31:0] i_ref_due,
    input  logic [31:0] i_ref_id,
    output t_cmp_flags  o_flags
);

    logic [31:0] d_now;
    logic [31:0] d_ref;

    // Due times are ordered by the sign of their 32-bit difference.
    assign d_now = i_cand_due - i_now;
    assign d_ref = i_cand_due - i_ref_due;

    assign o_flags.is_due     = (d_now == 32'd0) || d_now[31];
    assign o_flags.is_earlier = (d_ref != 32'd0) ? d_ref[31] : (i_cand_id < i_ref_id);

endmodule

// ----- rtl/tqoe_entry_mem.sv -----
module tqoe_entry_mem
    import tqoe_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_entry            o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tqoe_result_buf.sv -----
module tqoe_result_buf
    import tqoe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [RES_W-1:0] i_waddr,
    input  t_result          i_wdata,
    input  logic             i_re,
    input  logic [RES_W-1:0] i_raddr,
    output t_result          o_rdata
);

    t_result r_mem [MAX_RESULTS];
    t_result r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/timer_queue_ordered_expiry_unit.sv -----
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_mode, i_delay, i_interval, i_target_id
// result    out        o_out_valid / i_out_ready  o_result_kind, o_timer_id, o_fire_count,
//                                                 o_any_active, o_last
//
// One transaction is taken at a time; o_in_ready is high only while the unit is idle.
// An add or a cancel walks the timer table one slot per cycle.
// A tick runs one table scan through the order comparator per firing, plus an update of the
// fired entry, and one final scan that finds nothing.
// Each result is read from the result buffer in S_ORD, then offered in S_OSHOW until i_out_ready.
// Reset is synchronous and active low; the table needs no clearing pass after it.
module timer_queue_ordered_expiry_unit
    import tqoe_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [23:0] i_delay,
    input  logic [23:0] i_interval,
    input  logic [31:0] i_target_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_result_kind,
    output logic [31:0] o_timer_id,
    output logic [31:0] o_fire_count,
    output logic        o_any_active,
    output logic        o_last
);

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_CAN   = 3'd2;
    localparam logic [2:0] S_TSCAN = 3'd3;
    localparam logic [2:0] S_TFIRE = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OSHOW = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [31:0]            r_time, n_time;
    logic [31:0]            r_next_id, n_next_id;
    logic [TIMER_SLOTS-1:0] r_active, n_active;
    logic [TIMER_SLOTS-1:0] r_fired, n_fired;
    logic [SLOT_W-1:0]      r_idx, n_idx;
    logic                   r_issued_all, n_issued_all;
    logic                   r_rd_vld, n_rd_vld;
    logic [SLOT_W-1:0]      r_rd_slot, n_rd_slot;
    logic                   r_best_found, n_best_found;
    logic [SLOT_W-1:0]      r_best_slot, n_best_slot;
    t_entry                 r_best, n_best;
    logic [CNT_W-1:0]       r_nres, n_nres;
    logic [RES_W-1:0]       r_outi, n_outi;
    logic [23:0]            r_delay;
    logic [23:0]            r_interval;
    logic [31:0]            r_target;

    logic              ent_we;
    logic [SLOT_W-1:0] ent_waddr;
    t_entry            ent_wdata;
    logic              ent_re;
    t_entry            ent_rdata;
    logic              res_we;
    logic [RES_W-1:0]  res_waddr;
    t_result           res_wdata;
    logic              res_re;
    t_result           res_rdata;
    t_cmp_flags        cmp;
    logic              cand_ok;
    logic              in_fire;
    t_entry            upd;

    tqoe_entry_mem #(
        .DEPTH  (TIMER_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_entry_mem (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (r_idx),
        .o_rdata (ent_rdata)
    );

    tqoe_result_buf u_result_buf (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_re    (res_re),
        .i_raddr (r_outi),
        .o_rdata (res_rdata)
    );

    tqoe_order_cmp u_order_cmp (
        .i_now      (r_time),
        .i_cand_due (ent_rdata.due),
        .i_cand_id  (ent_rdata.id),
        .i_ref_due  (r_best.due),
        .i_ref_id   (r_best.id),
        .o_flags    (cmp)
    );

    assign in_fire = i_in_valid && o_in_ready;
    assign cand_ok = r_active[r_rd_slot] && !r_fired[r_rd_slot] && cmp.is_due;

    always_comb begin
        n_state      = r_state;
        n_time       = r_time;
        n_next_id    = r_next_id;
        n_active     = r_active;
        n_fired      = r_fired;
        n_idx        = r_idx;
        n_issued_all = r_issued_all;
        n_rd_slot    = r_idx;
        n_best_found = r_best_found;
        n_best_slot  = r_best_slot;
        n_best       = r_best;
        n_nres       = r_nres;
        n_outi       = r_outi;
        ent_we       = 1'b0;
        ent_waddr    = r_idx;
        ent_wdata    = r_best;
        ent_re       = 1'b0;
        res_we       = 1'b0;
        res_waddr    = r_nres[RES_W-1:0];
        res_wdata    = '0;
        res_re       = 1'b0;
        upd          = r_best;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx        = '0;
                    n_issued_all = 1'b0;
                    n_best_found = 1'b0;
                    n_nres       = '0;
                    n_outi       = '0;
                    unique case (i_mode)
                        MODE_ADD: begin
                            n_state = S_ADD;
                        end
                        MODE_CANCEL: begin
                            n_state = S_CAN;
                        end
                        MODE_TICK: begin
                            n_time  = r_time + 32'd1;
                            n_fired = '0;
                            n_state = S_TSCAN;
                        end
                        default: begin
                            res_we         = 1'b1;
                            res_waddr      = '0;
                            res_wdata.kind = KIND_NONE;
                            n_nres         = CNT_W'(1);
                            n_state        = S_ORD;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (!r_active[r_idx]) begin
                    ent_we           = 1'b1;
                    ent_wdata.id     = r_next_id;
                    ent_wdata.due    = r_time + {8'd0, r_delay};
                    ent_wdata.period = r_interval;
                    ent_wdata.fires  = 32'd0;
                    n_active[r_idx]  = 1'b1;
                    n_next_id        = (r_next_id == 32'hFFFF_FFFF) ? 32'd1
                                                                    : r_next_id + 32'd1;
                    res_we           = 1'b1;
                    res_wdata.kind   = KIND_ADDED;
                    res_wdata.id     = r_next_id;
                    n_nres           = r_nres + CNT_W'(1);
                    n_state          = S_ORD;
                end else if (r_idx == LAST_SLOT) begin
                    res_we         = 1'b1;
                    res_wdata.kind = KIND_FULL;
                    n_nres         = r_nres + CNT_W'(1);
                    n_state        = S_ORD;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_CAN: begin
                ent_re = !r_issued_all;
                if (!r_issued_all) begin
                    if (r_idx == LAST_SLOT) begin
                        n_issued_all = 1'b1;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
                if (r_rd_vld) begin
                    if (r_active[r_rd_slot] && (ent_rdata.id == r_target)) begin
                        n_active[r_rd_slot] = 1'b0;
                        res_we              = 1'b1;
                        res_wdata.kind      = KIND_CANCELLED;
                        res_wdata.id        = r_target;
                        n_nres              = r_nres + CNT_W'(1);
                        n_state             = S_ORD;
                    end else if (r_rd_slot == LAST_SLOT) begin
                        res_we         = 1'b1;
                        res_wdata.kind = KIND_UNKNOWN;
                        n_nres         = r_nres + CNT_W'(1);
                        n_state        = S_ORD;
                    end
                end
            end
            S_TSCAN: begin
                ent_re = !r_issued_all;
                if (!r_issued_all) begin
                    if (r_idx == LAST_SLOT) begin
                        n_issued_all = 1'b1;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
                if (r_rd_vld) begin
                    if (cand_ok && (!r_best_found || cmp.is_earlier)) begin
                        n_best_found = 1'b1;
                        n_best_slot  = r_rd_slot;
                        n_best       = ent_rdata;
                    end
                    if (r_rd_slot == LAST_SLOT) begin
                        if ((r_best_found || cand_ok) && (r_nres < CNT_W'(MAX_RESULTS))) begin
                            n_state = S_TFIRE;
                        end else begin
                            if (r_nres == '0) begin
                                res_we         = 1'b1;
                                res_wdata.kind = KIND_NONE;
                                n_nres         = CNT_W'(1);
                            end
                            n_state = S_ORD;
                        end
                    end
                end
            end
            S_TFIRE: begin
                upd.fires = r_best.fires + 32'd1;
                if (r_best.period != 24'd0) begin
                    upd.due = r_best.due + {8'd0, r_best.period};
                end else begin
                    n_active[r_best_slot] = 1'b0;
                end
                ent_we               = 1'b1;
                ent_waddr            = r_best_slot;
                ent_wdata            = upd;
                n_fired[r_best_slot] = 1'b1;
                res_we               = 1'b1;
                res_wdata.kind       = KIND_FIRED;
                res_wdata.id         = r_best.id;
                res_wdata.fires      = upd.fires;
                n_nres               = r_nres + CNT_W'(1);
                n_idx                = '0;
                n_issued_all         = 1'b0;
                n_best_found         = 1'b0;
                n_state              = S_TSCAN;
            end
            S_ORD: begin
                res_re  = 1'b1;
                n_state = S_OSHOW;
            end
            S_OSHOW: begin
                if (i_out_ready) begin
                    if (o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_outi  = r_outi + RES_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rd_vld = ent_re;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_time       <= 32'd0;
            r_next_id    <= 32'd1;
            r_active     <= '0;
            r_fired      <= '0;
            r_idx        <= '0;
            r_issued_all <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_rd_slot    <= '0;
            r_best_found <= 1'b0;
            r_best_slot  <= '0;
            r_nres       <= '0;
            r_outi       <= '0;
        end else begin
            r_state      <= n_state;
            r_time       <= n_time;
            r_next_id    <= n_next_id;
            r_active     <= n_active;
            r_fired      <= n_fired;
            r_idx        <= n_idx;
            r_issued_all <= n_issued_all;
            r_rd_vld     <= n_rd_vld;
            r_rd_slot    <= n_rd_slot;
            r_best_found <= n_best_found;
            r_best_slot  <= n_best_slot;
            r_nres       <= n_nres;
            r_outi       <= n_outi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        if (in_fire) begin
            r_delay    <= i_delay;
            r_interval <= i_interval;
            r_target   <= i_target_id;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OSHOW);
    assign o_result_kind = res_rdata.kind;
    assign o_timer_id    = res_rdata.id;
    assign o_fire_count  = res_rdata.fires;
    assign o_any_active  = |r_active;
    assign o_last        = ({1'b0, r_outi} == (r_nres - CNT_W'(1)));

`ifndef SYNTHESIS
    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= CNT_W'(MAX_RESULTS))
        else $error("result count exceeds the buffer depth");

    a_ready_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is offered");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after an input transaction");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> (!o_out_valid && o_in_ready))
        else $error("results continue after the last one");
`endif

endmodule

// ----- bench/timer_queue_ordered_expiry_checker.sv -----
`timescale 1ns / 100ps

module timer_queue_ordered_expiry_checker
    import tqoe_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [23:0] i_delay,
    input  logic [23:0] i_interval,
    input  logic [31:0] i_target_id,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_result_kind,
    input  logic [31:0] i_timer_id,
    input  logic [31:0] i_fire_count,
    input  logic        i_any_active,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] fires;
        logic        active;
        logic        last;
    } t_outcome;

    logic [31:0]            clock_now;
    logic [31:0]            id_next;
    logic [TIMER_SLOTS-1:0] slot_busy;
    logic [31:0]            slot_id     [TIMER_SLOTS];
    logic [31:0]            slot_due    [TIMER_SLOTS];
    logic [23:0]            slot_period [TIMER_SLOTS];
    logic [31:0]            slot_fires  [TIMER_SLOTS];

    t_outcome awaited_outcomes[$];
    int       fail_total = 0;
    int       results_seen = 0;

    task automatic report_mismatch(input string msg);
        if (fail_total < 50) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        fail_total++;
    endtask

    // Due times wrap, so the order is decided by the sign of the difference.
    function automatic logic fires_earlier(input int a, input int b);
        logic [31:0] gap;
        gap = slot_due[a] - slot_due[b];
        if (gap != 32'd0) begin
            return gap[31];
        end
        return slot_id[a] < slot_id[b];
    endfunction

    task automatic step_timer_table(input logic [1:0] mode, input logic [23:0] delay,
                                    input logic [23:0] interval, input logic [31:0] target);
        t_outcome    batch[$];
        t_outcome    rec;
        int          due_order[TIMER_SLOTS];
        int          due_cnt;
        int          found;
        int          hold;
        logic [31:0] gap;
        rec = '0;
        due_cnt = 0;
        found = -1;
        if (mode == MODE_ADD) begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                if (!slot_busy[i] && found < 0) found = i;
            end
            if (found < 0) begin
                rec.kind = KIND_FULL;
            end else begin
                rec.kind = KIND_ADDED;
                rec.id = id_next;
                id_next = id_next + 32'd1;
                if (id_next == 32'd0) id_next = 32'd1;
                slot_busy[found]   = 1'b1;
                slot_id[found]     = rec.id;
                slot_due[found]    = clock_now + {8'd0, delay};
                slot_period[found] = interval;
                slot_fires[found]  = 32'd0;
            end
            batch.push_back(rec);
        end else if (mode == MODE_CANCEL) begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                if (slot_busy[i] && slot_id[i] == target && found < 0) found = i;
            end
            if (found < 0) begin
                rec.kind = KIND_UNKNOWN;
            end else begin
                rec.kind = KIND_CANCELLED;
                rec.id = target;
                slot_busy[found] = 1'b0;
            end
            batch.push_back(rec);
        end else if (mode == MODE_TICK) begin
            clock_now = clock_now + 32'd1;
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                gap = slot_due[i] - clock_now;
                if (slot_busy[i] && (gap == 32'd0 || gap[31])) begin
                    due_order[due_cnt] = i;
                    due_cnt++;
                end
            end
            for (int i = 1; i < due_cnt; i++) begin
                for (int k = i; k > 0; k--) begin
                    if (!fires_earlier(due_order[k], due_order[k-1])) break;
                    hold = due_order[k];
                    due_order[k] = due_order[k-1];
                    due_order[k-1] = hold;
                end
            end
            if (due_cnt > MAX_RESULTS) due_cnt = MAX_RESULTS;
            for (int k = 0; k < due_cnt; k++) begin
                found = due_order[k];
                slot_fires[found] = slot_fires[found] + 32'd1;
                if (slot_period[found] != 24'd0) begin
                    slot_due[found] = slot_due[found] + {8'd0, slot_period[found]};
                end else begin
                    slot_busy[found] = 1'b0;
                end
                rec.kind  = KIND_FIRED;
                rec.id    = slot_id[found];
                rec.fires = slot_fires[found];
                batch.push_back(rec);
            end
            if (due_cnt == 0) begin
                rec.kind = KIND_NONE;
                batch.push_back(rec);
            end
        end else begin
            rec.kind = KIND_NONE;
            batch.push_back(rec);
        end
        for (int k = 0; k < batch.size(); k++) begin
            rec = batch[k];
            rec.active = |slot_busy;
            rec.last = (k == batch.size() - 1);
            awaited_outcomes.push_back(rec);
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, field, got, want));
        end
    endtask

    task automatic check_outcome();
        t_outcome want;
        if (awaited_outcomes.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected (kind %0d id %0d)",
                                      results_seen, i_result_kind, i_timer_id));
        end else begin
            want = awaited_outcomes.pop_front();
            compare_field("result_kind", {29'd0, i_result_kind}, {29'd0, want.kind});
            compare_field("timer_id", i_timer_id, want.id);
            compare_field("fire_count", i_fire_count, want.fires);
            compare_field("any_active", {31'd0, i_any_active}, {31'd0, want.active});
            compare_field("last", {31'd0, i_last}, {31'd0, want.last});
        end
        results_seen++;
    endtask

    // The result side is checked first: a result in the same cycle as a new
    // transaction always belongs to an earlier one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clock_now = '0;
            id_next = 32'd1;
            slot_busy = '0;
            awaited_outcomes.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_outcome();
            if (i_in_valid && i_in_ready) begin
                step_timer_table(i_mode, i_delay, i_interval, i_target_id);
            end
        end
        o_pending = awaited_outcomes.size();
        o_fail_count = fail_total;
    end

endmodule

// ----- bench/timer_queue_ordered_expiry_unit_tb.sv -----
`timescale 1ns / 100ps

module timer_queue_ordered_expiry_unit_tb;
    import tqoe_pkg::*;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS   = 200;
    localparam int         CALM_FROM      = 170;
    localparam int         WATCHDOG_LIMIT = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode = '0;
    logic [23:0] i_delay = '0;
    logic [23:0] i_interval = '0;
    logic [31:0] i_target_id = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_result_kind;
    logic [31:0] o_timer_id;
    logic [31:0] o_fire_count;
    logic        o_any_active;
    logic        o_last;

    int   fail_count;
    int   pending;
    int   adds_sent = 0;
    int   quiet_cycles = 0;
    int   stall_left = 0;
    int   ready_cycle = 0;
    logic calm = 1'b0;

    timer_queue_ordered_expiry_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_delay      (i_delay),
        .i_interval   (i_interval),
        .i_target_id  (i_target_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result_kind(o_result_kind),
        .o_timer_id   (o_timer_id),
        .o_fire_count (o_fire_count),
        .o_any_active (o_any_active),
        .o_last       (o_last)
    );

    timer_queue_ordered_expiry_checker table_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_delay      (i_delay),
        .i_interval   (i_interval),
        .i_target_id  (i_target_id),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_result_kind(o_result_kind),
        .i_timer_id   (o_timer_id),
        .i_fire_count (o_fire_count),
        .i_any_active (o_any_active),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        ready_cycle <= ready_cycle + 1;
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && ready_cycle[7:6] != 2'b11 && $urandom_range(0, 4) == 0) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d cycles without a transaction", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Returns at the edge where the transaction was taken, with valid still high.
    task automatic send_item(input logic [1:0] mode, input logic [23:0] delay,
                             input logic [23:0] interval, input logic [31:0] target);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_delay     <= delay;
        i_interval  <= interval;
        i_target_id <= target;
        if (mode == MODE_ADD) adds_sent++;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random(input int idx);
        int          pick;
        int          add_share;
        logic [1:0]  mode;
        logic [23:0] delay;
        logic [23:0] interval;
        logic [31:0] target;
        pick = $urandom_range(0, 99);
        add_share = ((idx / 40) % 2 == 0) ? 55 : 25;
        delay = 24'($urandom);
        interval = 24'($urandom);
        target = $urandom;
        if (pick < add_share) begin
            mode = MODE_ADD;
            if ($urandom_range(0, 9) != 0) delay = 24'($urandom_range(0, 6));
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                interval = '0;
            end else if (pick < 9) begin
                interval = 24'($urandom_range(1, 6));
            end
        end else if (pick < add_share + 15) begin
            mode = MODE_CANCEL;
            if ($urandom_range(0, 7) != 0) target = $urandom_range(1, adds_sent + 1);
        end else if (pick < add_share + 20) begin
            mode = 2'($urandom_range(0, 3));
        end else begin
            mode = MODE_TICK;
        end
        send_item(mode, delay, interval, target);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(MODE_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
        send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_CANCEL, '0, '0, 32'd0);
        send_item(MODE_ADD, 24'd0, 24'd0, '0);
        send_item(MODE_ADD, 24'hFFFFFF, 24'hFFFFFF, '0);
        send_item(MODE_TICK, '0, '0, '0);
        // Fill the table with mixed due times and repeat periods.
        for (int k = 0; k < 15; k++) begin
            send_item(MODE_ADD, (k % 2 == 0) ? 24'd1 : 24'd0, 24'(k % 3), '0);
        end
        send_item(MODE_ADD, 24'd3, 24'd0, '0);
        send_item(MODE_CANCEL, '0, '0, 32'd2);
        send_item(MODE_CANCEL, '0, '0, 32'd2);
        // The newest entry sits in a low slot but is among the earliest due.
        send_item(MODE_ADD, 24'd0, 24'd0, '0);
        repeat (3) send_item(MODE_TICK, '0, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 60 || n == 120) drain_results();
            if (n == CALM_FROM) calm = 1'b1;
            send_random(n);
        end
        drain_results();
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
